### src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator: request and
// response beats, action and status codes, controller states and map sizing.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Number of 4 KiB frames under management.
    localparam int FRAMES     = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_WORDS  = (FRAMES + 31) / 32;
    localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FREE_W     = $clog2(FRAMES + 1);
    // Frame numbers carry 20 bits; the limit compared against them is one bit wider.
    localparam int FRAME_W    = 32 - PAGE_SHIFT;

    // Request action codes.
    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Response status codes.
    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_FRAME = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_UNUSED   = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_DONE
    } state_t;

    // One request beat.
    typedef struct packed {
        action_t     action;
        logic [31:0] frame_address;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic [31:0] granted_address;
        status_t     status;
        logic [16:0] frames_left;
    } rsp_t;

    // Result of the lowest-clear-bit search on one map word.
    typedef struct packed {
        logic       found;
        logic [4:0] index;
    } bit_hit_t;

endpackage

### src/bfa_bit_find.sv
// ----------------------------------------------------------------------------
// bfa_bit_find
// Finds the lowest clear bit of one 32-bit map word (a clear bit is a free
// frame) and reports whether any bit is clear.
// ----------------------------------------------------------------------------
module bfa_bit_find (
    input  logic [31:0]       word,
    output bfa_pkg::bit_hit_t hit
);

    // Priority encoder, lowest index wins.
    always_comb
    begin
        hit.found = 1'b0;
        hit.index = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word[i])
            begin
                hit.found = 1'b1;
                hit.index = 5'(i);
            end
        end
    end

endmodule

### src/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame used map held in a
// single-port-read, single-port-write synchronous RAM, 32 frames per word.
// ----------------------------------------------------------------------------
// Flow: free and reserve read the map word, then update it in S_RMW;
// allocate reads map words upward from the scan hint to the first word with
// a free frame; beats with no map access (range error, no free frame) go
// straight to the response. Throughput: one beat in work at a time; a new
// beat is taken while a response waits.
// Reset: a clearing pass marks all 2048 map words used, one per cycle.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bfa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bfa_pkg::rsp_t rsp
);

    localparam logic [bfa_pkg::WORD_AW-1:0] LAST_WORD =
        bfa_pkg::WORD_AW'(bfa_pkg::MAP_WORDS - 1);
    localparam logic [bfa_pkg::FRAME_W:0] FRAME_LIMIT =
        (bfa_pkg::FRAME_W + 1)'(bfa_pkg::FRAMES);

    bfa_pkg::state_t  state_reg, state_next;
    bfa_pkg::action_t op_reg, op_next;
    logic [bfa_pkg::WORD_AW-1:0] word_reg, word_next;
    logic [4:0]                  bit_reg, bit_next;
    logic [31:0]                 res_addr_reg, res_addr_next;
    bfa_pkg::status_t            res_status_reg, res_status_next;
    logic [bfa_pkg::FREE_W-1:0]  free_total_reg, free_total_next;
    logic [bfa_pkg::WORD_AW-1:0] hint_reg, hint_next;
    logic [bfa_pkg::WORD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    bfa_pkg::rsp_t               out_data_reg, out_data_next;

    // Map RAM ports.
    logic [31:0]                 map_mem [bfa_pkg::MAP_WORDS];
    logic [31:0]                 rdata_reg;
    logic [bfa_pkg::WORD_AW-1:0] mem_raddr;
    logic                        mem_we;
    logic [bfa_pkg::WORD_AW-1:0] mem_waddr;
    logic [31:0]                 mem_wdata;

    logic [bfa_pkg::FRAME_W-1:0]   req_frame;
    logic                          req_in_range;
    logic [bfa_pkg::WORD_AW-1:0]   req_word;
    logic                          slot_free;
    logic                          scan_last;
    logic [31:0]                   bit_mask;
    logic                          cur_bit;
    bfa_pkg::bit_hit_t             hit;

    // Request decode.
    assign req_frame    = req.frame_address[31:bfa_pkg::PAGE_SHIFT];
    assign req_in_range = {1'b0, req_frame} < FRAME_LIMIT;
    assign req_word     = req_frame[bfa_pkg::WORD_AW+4:5];
    assign slot_free    = !out_valid_reg || !rsp_stall;
    assign scan_last    = (word_reg == LAST_WORD);
    assign bit_mask     = 32'd1 << bit_reg;
    assign cur_bit      = rdata_reg[bit_reg];

    // Lowest free frame of the word just read.
    bfa_bit_find u_bit_find (
        .word (rdata_reg),
        .hit  (hit)
    );

    // Map RAM: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_raddr];
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfa_pkg::S_CLEAR;
            free_total_reg <= '0;
            hint_reg       <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            hint_reg       <= hint_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfa_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action) inside
                        bfa_pkg::ACT_ALLOC:
                            state_next = (free_total_reg == '0) ? bfa_pkg::S_DONE
                                                                : bfa_pkg::S_SCAN;
                        bfa_pkg::ACT_FREE, bfa_pkg::ACT_RESERVE:
                            state_next = req_in_range ? bfa_pkg::S_RMW
                                                      : bfa_pkg::S_DONE;
                        default:
                            state_next = bfa_pkg::S_DONE;
                    endcase
                end
            end
            bfa_pkg::S_SCAN:
            begin
                if (hit.found || scan_last)
                begin
                    state_next = bfa_pkg::S_DONE;
                end
            end
            bfa_pkg::S_RMW:
            begin
                state_next = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::S_CLEAR;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        op_next         = op_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        free_total_next = free_total_reg;
        hint_next       = hint_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        req_stall       = 1'b1;
        mem_raddr       = word_reg;
        mem_we          = 1'b0;
        mem_waddr       = word_reg;
        mem_wdata       = rdata_reg;

        unique case (state_reg)
            // Sweep the map to all used, one word per cycle.
            bfa_pkg::S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end

            // Take a request and start its map read.
            bfa_pkg::S_IDLE:
            begin
                req_stall       = 1'b0;
                op_next         = req.action;
                bit_next        = req_frame[4:0];
                res_addr_next   = '0;
                res_status_next = bfa_pkg::STAT_DONE;
                if (req.action == bfa_pkg::ACT_ALLOC)
                begin
                    word_next = hint_reg;
                    mem_raddr = hint_reg;
                    if (free_total_reg == '0)
                    begin
                        res_status_next = bfa_pkg::STAT_NO_FRAME;
                    end
                end
                else
                begin
                    word_next = req_word;
                    mem_raddr = req_word;
                    if ((req.action == bfa_pkg::ACT_FREE ||
                         req.action == bfa_pkg::ACT_RESERVE) && !req_in_range)
                    begin
                        res_status_next = bfa_pkg::STAT_RANGE;
                    end
                end
            end

            // Walk words upward; the next read is issued speculatively.
            bfa_pkg::S_SCAN:
            begin
                mem_raddr = word_reg + 1'b1;
                if (hit.found)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = rdata_reg | (32'd1 << hit.index);
                    free_total_next = free_total_reg - 1'b1;
                    hint_next       = word_reg;
                    res_addr_next   = 32'({word_reg, hit.index}) << bfa_pkg::PAGE_SHIFT;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                    if (scan_last)
                    begin
                        res_status_next = bfa_pkg::STAT_NO_FRAME;
                    end
                end
            end

            // Flip one bit of the word read; count only real changes.
            bfa_pkg::S_RMW:
            begin
                if (op_reg == bfa_pkg::ACT_FREE)
                begin
                    if (cur_bit)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = rdata_reg & ~bit_mask;
                        free_total_next = free_total_reg + 1'b1;
                    end
                    if (word_reg < hint_reg)
                    begin
                        hint_next = word_reg;
                    end
                end
                else if (!cur_bit)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = rdata_reg | bit_mask;
                    free_total_next = free_total_reg - 1'b1;
                end
            end

            // Hand the result to the output register once it is free.
            bfa_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.granted_address = res_addr_reg;
                    out_data_next.status          = res_status_reg;
                    out_data_next.frames_left     = 17'(free_total_reg);
                end
            end

            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

### src/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the bitmap frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input bfa_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bfa_pkg::rsp_t rsp
);

    // A stalled request beat holds its payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request beat changed while stalled");

    // Only one request is in work: an accepted beat stalls the next one.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another was in work");

    // A stalled response beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // A granted address is only given with a done status.
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bfa_pkg::STAT_DONE |-> rsp.granted_address == 32'd0)
        else $error("address granted with an error status");

    // An out-of-frames response leaves no frame free.
    a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == bfa_pkg::STAT_NO_FRAME |-> rsp.frames_left == 17'd0)
        else $error("out of frames reported with free frames left");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
